@@ design/mbt_pkg.sv @@
package mbt_pkg;

    // Default widths, handed to the top level as parameter defaults
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 28;
    localparam int ITER_BITS_DEF = 16;

    // Configuration register map
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MAX_ITERATIONS      = 2'd0,
        CFG_BULB_CHECK_ENABLE   = 2'd1,
        CFG_PERIOD_CHECK_ENABLE = 2'd2
    } cfg_index_t;

    localparam int RESET_MAX_ITERATIONS = 256;

    // First periodicity window, doubled after each re-save
    localparam int FIRST_WINDOW = 8;

    // Result reason codes
    typedef enum logic [2:0] {
        REASON_ESCAPED  = 3'd0,
        REASON_CARDIOID = 3'd1,
        REASON_BULB     = 3'd2,
        REASON_CYCLE    = 3'd3,
        REASON_LIMIT    = 3'd4
    } reason_t;

    typedef struct packed {
        logic bulb_check_enable;
        logic period_check_enable;
    } cfg_flags_t;

    // Operand routing for the three multipliers
    typedef enum logic [1:0] {
        MUL_ITER = 2'd0,
        MUL_BULB = 2'd1,
        MUL_CARD = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     bulb_sum;
        logic     z_update;
        logic     iter_step;
    } dp_cmd_t;

    typedef struct packed {
        logic near_origin;
        logic card_hit;
        logic bulb_hit;
        logic period_eq;
        logic escape;
        logic limit;
        logic max_zero;
    } dp_status_t;

endpackage

@@ design/mbt_if.sv @@
interface mbt_point_if #(
    parameter int WORD_BITS = mbt_pkg::WORD_BITS_DEF
);
    import mbt_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] c_real;
    logic signed [WORD_BITS-1:0] c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbt_result_if;
    import mbt_pkg::*;

    logic       valid;
    logic       ready;
    logic       in_set;
    logic [2:0] reason;

    modport source (output valid, output in_set, output reason, input ready);
    modport sink   (input valid, input in_set, input reason, output ready);
endinterface

interface mbt_cfg_if #(
    parameter int ITER_BITS = mbt_pkg::ITER_BITS_DEF
);
    import mbt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [ITER_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/mbt_cfg_regs.sv @@
module mbt_cfg_regs #(
    parameter int ITER_BITS = mbt_pkg::ITER_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    mbt_cfg_if.sink                cfg,
    output logic [ITER_BITS-1:0]   max_iterations,
    output mbt_pkg::cfg_flags_t    flags
);
    import mbt_pkg::*;

    logic [ITER_BITS-1:0] max_iterations_reg;
    cfg_flags_t           flags_reg;

    // Always take a write
    assign cfg.ready = 1'b1;

    // Hold the registers; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iterations_reg            <= ITER_BITS'(RESET_MAX_ITERATIONS);
            flags_reg.bulb_check_enable   <= 1'b1;
            flags_reg.period_check_enable <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MAX_ITERATIONS:      max_iterations_reg <= cfg.data;
                CFG_BULB_CHECK_ENABLE:   flags_reg.bulb_check_enable <= cfg.data[0];
                CFG_PERIOD_CHECK_ENABLE: flags_reg.period_check_enable <= cfg.data[0];
                default:                 ;
            endcase
        end
    end

    assign max_iterations = max_iterations_reg;
    assign flags          = flags_reg;

endmodule

@@ design/mbt_datapath.sv @@
module mbt_datapath #(
    parameter int WORD_BITS = mbt_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = mbt_pkg::FRAC_BITS_DEF,
    parameter int ITER_BITS = mbt_pkg::ITER_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic signed [WORD_BITS-1:0] c_real,
    input  logic signed [WORD_BITS-1:0] c_imag,
    input  logic [ITER_BITS-1:0]        max_iterations,
    input  mbt_pkg::dp_cmd_t            cmd,
    output mbt_pkg::dp_status_t         status
);
    import mbt_pkg::*;

    // Multiplier operand width: covers c itself and any z within +-2,
    // and the cardioid terms q and q + x - 1/4 once c is near the origin
    localparam int MW = (WORD_BITS > FRAC_BITS + 4) ? WORD_BITS : FRAC_BITS + 4;
    localparam int PW = 2 * MW;
    // Working width for z: holds the first iterate of the largest c
    localparam int ZW = 2 * WORD_BITS - FRAC_BITS + 8;
    localparam int CW = ITER_BITS + 1;

    localparam logic signed [ZW-1:0] ONE_FX       = ZW'(1) << FRAC_BITS;
    localparam logic signed [ZW-1:0] TWO_FX       = ZW'(2) << FRAC_BITS;
    localparam logic signed [ZW-1:0] FOUR_FX      = ZW'(4) << FRAC_BITS;
    localparam logic signed [ZW-1:0] QUARTER_FX   = ZW'(1) << (FRAC_BITS - 2);
    localparam logic signed [ZW-1:0] SIXTEENTH_FX = ZW'(1) << (FRAC_BITS - 4);

    // Floor a raw product to the working format
    function automatic logic signed [ZW-1:0] fx_floor(input logic signed [PW-1:0] p,
                                                      input int sh);
        logic signed [PW-1:0] s;
        s = p >>> sh;
        return ZW'(s);
    endfunction

    logic signed [WORD_BITS-1:0] cr_reg, ci_reg;
    logic signed [MW-1:0]        xm_reg, xp_reg, q_reg, qx_reg;
    logic signed [ZW-1:0]        zr_reg, zi_reg, tr_reg, ti_reg, y2q_reg;
    logic signed [PW-1:0]        p0_reg, p1_reg, p2_reg;
    logic                        bulb_hit_reg, big_reg;
    logic [ITER_BITS-1:0]        it_reg;
    logic [CW-1:0]               idx_reg, window_reg;

    logic signed [ZW-1:0] c_real_ext, cr_ext, ci_ext;
    logic signed [ZW-1:0] sq_r, sq_i, sq_x, sq_p2, sq_sum, qx_sum, zr_new, zi_new;
    logic signed [MW-1:0] a0, b0, a1, b1, a2, b2;
    logic                 big_now;
    logic [CW-1:0]        idx_inc;
    logic                 idx_hit;
    logic [ITER_BITS:0]   it_inc;

    assign c_real_ext = ZW'(c_real);
    assign cr_ext     = ZW'(cr_reg);
    assign ci_ext     = ZW'(ci_reg);

    // Floor the registered products
    assign sq_r   = fx_floor(p0_reg, FRAC_BITS);
    assign sq_i   = fx_floor(p1_reg, FRAC_BITS);
    assign sq_p2  = fx_floor(p2_reg, FRAC_BITS);
    assign sq_x   = fx_floor(p2_reg, FRAC_BITS - 1);
    assign sq_sum = sq_r + sq_i;
    assign qx_sum = sq_sum + ZW'(xm_reg);

    // Next iterate from the squares of the current one
    assign zr_new = sq_r - sq_i + cr_ext;
    assign zi_new = sq_x + ci_ext;

    // A component beyond +-2 escapes for certain
    assign big_now = (zr_reg > TWO_FX) || (zr_reg < -TWO_FX)
                  || (zi_reg > TWO_FX) || (zi_reg < -TWO_FX);

    // Route multiplier operands
    always_comb
    begin
        a0 = MW'(zr_reg);
        b0 = MW'(zr_reg);
        a1 = MW'(zi_reg);
        b1 = MW'(zi_reg);
        a2 = MW'(zr_reg);
        b2 = MW'(zi_reg);
        case (cmd.mul_sel)
            MUL_ITER:
            begin
                a0 = MW'(zr_reg);
            end
            MUL_BULB:
            begin
                a0 = xm_reg;
                b0 = xm_reg;
                a1 = MW'(ci_reg);
                b1 = MW'(ci_reg);
                a2 = xp_reg;
                b2 = xp_reg;
            end
            MUL_CARD:
            begin
                a0 = q_reg;
                b0 = qx_reg;
            end
            default:
            begin
                a0 = MW'(zr_reg);
            end
        endcase
    end

    // Capture the point, products and bulb terms
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg <= c_real;
            ci_reg <= c_imag;
            xm_reg <= MW'(c_real_ext - QUARTER_FX);
            xp_reg <= MW'(c_real_ext + ONE_FX);
        end
        if (cmd.mul_en)
        begin
            p0_reg <= a0 * b0;
            p1_reg <= a1 * b1;
            p2_reg <= a2 * b2;
            if (cmd.mul_sel == MUL_ITER)
            begin
                big_reg <= big_now;
            end
        end
        if (cmd.bulb_sum)
        begin
            q_reg        <= MW'(sq_sum);
            qx_reg       <= MW'(qx_sum);
            y2q_reg      <= sq_i >>> 2;
            bulb_hit_reg <= (sq_p2 + sq_i) < SIXTEENTH_FX;
        end
    end

    assign idx_inc = idx_reg + CW'(1);
    assign idx_hit = (idx_inc == window_reg);
    assign it_inc  = {1'b0, it_reg} + CW'(1);

    // Advance z and re-save the periodicity copy at the end of a window
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            zr_reg <= c_real_ext;
            zi_reg <= ZW'(c_imag);
            tr_reg <= c_real_ext;
            ti_reg <= ZW'(c_imag);
        end
        else
        begin
            if (cmd.z_update)
            begin
                zr_reg <= zr_new;
                zi_reg <= zi_new;
            end
            if (cmd.iter_step && idx_hit)
            begin
                tr_reg <= zr_reg;
                ti_reg <= zi_reg;
            end
        end
    end

    // Iteration and window counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_reg     <= '0;
            idx_reg    <= '0;
            window_reg <= CW'(FIRST_WINDOW);
        end
        else if (cmd.load)
        begin
            it_reg     <= '0;
            idx_reg    <= '0;
            window_reg <= CW'(FIRST_WINDOW);
        end
        else if (cmd.iter_step)
        begin
            it_reg <= it_inc[ITER_BITS-1:0];
            if (idx_hit)
            begin
                idx_reg    <= '0;
                window_reg <= {window_reg[CW-2:0], 1'b0};
            end
            else
            begin
                idx_reg <= idx_inc;
            end
        end
    end

    assign status.near_origin = (cr_ext > -TWO_FX) && (cr_ext < TWO_FX)
                             && (ci_ext > -ONE_FX) && (ci_ext < ONE_FX);
    assign status.card_hit    = sq_r < y2q_reg;
    assign status.bulb_hit    = bulb_hit_reg;
    assign status.period_eq   = (zr_reg == tr_reg) && (zi_reg == ti_reg);
    assign status.escape      = big_reg || (sq_sum > FOUR_FX);
    assign status.limit       = (it_inc == {1'b0, max_iterations});
    assign status.max_zero    = (max_iterations == '0);

    a_window_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(window_reg))
        else $error("periodicity window is not a single bit");

    a_idx_below_window: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg < window_reg) || (window_reg == '0))
        else $error("window position passed the window length");

    a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (zr_reg == tr_reg) && (zi_reg == ti_reg) && (it_reg == '0))
        else $error("new point did not start with z equal to the saved copy");

endmodule

@@ design/mbt_ctrl.sv @@
module mbt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbt_pkg::cfg_flags_t  flags,
    input  mbt_pkg::dp_status_t  status,
    output mbt_pkg::dp_cmd_t     cmd,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 out_in_set,
    output mbt_pkg::reason_t     out_reason
);
    import mbt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_BULB_MUL,
        ST_BULB_SUM,
        ST_CARD_MUL,
        ST_CARD_CMP,
        ST_SQ,
        ST_ADD,
        ST_FINISH
    } state_t;

    state_t  state_reg, state_next;
    logic    first_reg, first_next;
    reason_t reason_reg, reason_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_in_set_reg, out_in_set_next;
    reason_t out_reason_reg, out_reason_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Sequence one point through the shortcut tests and the iteration loop
    always_comb
    begin
        state_next      = state_reg;
        first_next      = first_reg;
        reason_next     = reason_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_in_set_next = out_in_set_reg;
        out_reason_next = out_reason_reg;
        cmd             = '0;
        cmd.mul_sel     = MUL_ITER;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    first_next = 1'b1;
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                if (flags.bulb_check_enable && status.near_origin)
                begin
                    state_next = ST_BULB_MUL;
                end
                else if (status.max_zero)
                begin
                    reason_next = REASON_LIMIT;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_BULB_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BULB;
                state_next  = ST_BULB_SUM;
            end
            ST_BULB_SUM:
            begin
                cmd.bulb_sum = 1'b1;
                state_next   = ST_CARD_MUL;
            end
            ST_CARD_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CARD;
                state_next  = ST_CARD_CMP;
            end
            ST_CARD_CMP:
            begin
                if (status.card_hit)
                begin
                    reason_next = REASON_CARDIOID;
                    state_next  = ST_FINISH;
                end
                else if (status.bulb_hit)
                begin
                    reason_next = REASON_BULB;
                    state_next  = ST_FINISH;
                end
                else if (status.max_zero)
                begin
                    reason_next = REASON_LIMIT;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ITER;
                if (!first_reg && flags.period_check_enable && status.period_eq)
                begin
                    reason_next = REASON_CYCLE;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (first_reg)
                begin
                    cmd.z_update = 1'b1;
                    first_next   = 1'b0;
                    state_next   = ST_SQ;
                end
                else if (status.escape)
                begin
                    reason_next = REASON_ESCAPED;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    cmd.iter_step = 1'b1;
                    if (status.limit)
                    begin
                        reason_next = REASON_LIMIT;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        cmd.z_update = 1'b1;
                        state_next   = ST_SQ;
                    end
                end
            end
            ST_FINISH:
            begin
                // Hand the item to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_in_set_next = (reason_reg != REASON_ESCAPED);
                    out_reason_next = reason_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_reg      <= 1'b0;
            reason_reg     <= REASON_ESCAPED;
            out_valid_reg  <= 1'b0;
            out_in_set_reg <= 1'b0;
            out_reason_reg <= REASON_ESCAPED;
        end
        else
        begin
            state_reg      <= state_next;
            first_reg      <= first_next;
            reason_reg     <= reason_next;
            out_valid_reg  <= out_valid_next;
            out_in_set_reg <= out_in_set_next;
            out_reason_reg <= out_reason_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_in_set = out_in_set_reg;
    assign out_reason = out_reason_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start work");

    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !out_valid_reg) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished item not moved to the output register");

    a_loop_reason_after_iterate: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH
            && (reason_reg == REASON_CYCLE || reason_reg == REASON_ESCAPED)) |-> !first_reg)
        else $error("escape or cycle reported before the first iterate");

endmodule

@@ design/mandelbrot_membership_test.sv @@
// Channel  Dir  Payload                                Handshake
// point    in   c_real, c_imag (signed Q4.28)          valid/ready
// result   out  in_set, reason                         valid/ready
// cfg      in   index, data (write only)               valid/ready, ready always high
//
// One point at a time. A point is loaded, then runs the cardioid and bulb tests when the
// bulb check is enabled and c is near the origin, then iterates until it escapes, cycles or
// reaches the iteration limit, and is then handed over. Each iteration runs the loop
// z -> three registered multipliers -> adder -> z.
// Reset clears control state and loads max_iterations 256 with both checks enabled.
// A new point is taken while a result waits in the output register; a finished point
// waits for that register before the next one is accepted.
module mandelbrot_membership_test #(
    parameter int WORD_BITS = mbt_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = mbt_pkg::FRAC_BITS_DEF,
    parameter int ITER_BITS = mbt_pkg::ITER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mbt_point_if.sink   point,
    mbt_result_if.source result,
    mbt_cfg_if.sink     cfg
);
    import mbt_pkg::*;

    logic [ITER_BITS-1:0] max_iterations;
    cfg_flags_t           cfg_flags;
    dp_cmd_t              dp_cmd;
    dp_status_t           dp_status;
    logic                 in_ready;
    logic                 out_valid;
    logic                 out_in_set;
    reason_t              out_reason;

    mbt_cfg_regs #(
        .ITER_BITS(ITER_BITS)
    ) u_cfg_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .max_iterations (max_iterations),
        .flags          (cfg_flags)
    );

    mbt_datapath #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS),
        .ITER_BITS(ITER_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .c_real         (point.c_real),
        .c_imag         (point.c_imag),
        .max_iterations (max_iterations),
        .cmd            (dp_cmd),
        .status         (dp_status)
    );

    mbt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .flags      (cfg_flags),
        .status     (dp_status),
        .cmd        (dp_cmd),
        .in_valid   (point.valid),
        .in_ready   (in_ready),
        .out_ready  (result.ready),
        .out_valid  (out_valid),
        .out_in_set (out_in_set),
        .out_reason (out_reason)
    );

    assign point.ready   = in_ready;
    assign result.valid  = out_valid;
    assign result.in_set = out_in_set;
    assign result.reason = out_reason;

endmodule
